// ----- rtl/cfcr_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte update for the frame
// command receiver. No dependencies; used by cfcr_parser and the top level.
package cfcr_pkg;

  // Frame limits
  localparam logic [7:0] PAYLOAD_LIMIT   = 8'd16;
  localparam logic [4:0] PWM_PAYLOAD_LEN = 5'd4;
  localparam logic [4:0] PAYLOAD_STORE   = 5'd4;

  // CRC-16/Modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_SET_PWM = 2'd1;
  localparam logic [1:0] EV_STOP    = 2'd2;
  localparam logic [1:0] EV_PING    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_START_FIRST  = 3'd0;
  localparam logic [2:0] REG_START_SECOND = 3'd1;
  localparam logic [2:0] REG_CODE_SET_PWM = 3'd2;
  localparam logic [2:0] REG_CODE_STOP    = 3'd3;
  localparam logic [2:0] REG_CODE_PING    = 3'd4;
  localparam logic [2:0] REG_BYTE_GAP     = 3'd5;
  localparam logic [2:0] REG_CMD_GAP      = 3'd6;

  localparam logic [15:0] GAP_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  start_byte_first;
    logic [7:0]  start_byte_second;
    logic [7:0]  code_set_pwm;
    logic [7:0]  code_stop;
    logic [7:0]  code_ping;
    logic [15:0] byte_gap_limit;
    logic [15:0] command_gap_limit;
  } cfcr_cfg_t;

  typedef struct packed {
    logic [1:0]         evt;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
  } cfcr_frame_t;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc_frame_command_receiver.sv -----
// Each accepted input item gives one result, held in the output register.
// Throughput: one item per cycle while results are taken; the output register frees as it is taken,
// so a new item is accepted while the previous result is being taken.
// Reset (rst, synchronous): parser hunts for a start byte, gap counters clear,
// no command seen and timeout raised, registers return to their defaults.
// Top level: configuration registers, command watchdog, output register.
module crc_frame_command_receiver (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] func: 0 byte, 1 tick
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [15:0] drive_a, [31:16] drive_b,
                                 // [32] command_timeout, [33] command_active, rest 0
  output logic [1:0]  m_tuser,   // [1:0] event_res
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cfcr_pkg::*;

  cfcr_cfg_t   cfg;
  cfcr_frame_t frame;
  logic        item_en;
  logic        is_tick;
  logic        command_seen, command_seen_next;
  logic        timeout_flag, timeout_flag_next;
  logic [15:0] command_gap_count, command_gap_count_next;
  logic        is_motor_cmd;

  assign s_tready  = !m_tvalid || m_tready;
  assign item_en   = s_tvalid && s_tready;
  assign is_tick   = s_tuser;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte_first  <= 8'hA5;
      cfg.start_byte_second <= 8'h5A;
      cfg.code_set_pwm      <= 8'd1;
      cfg.code_stop         <= 8'd2;
      cfg.code_ping         <= 8'd3;
      cfg.byte_gap_limit    <= 16'd20;
      cfg.command_gap_limit <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_FIRST:  cfg.start_byte_first  <= cfg_data[7:0];
        REG_START_SECOND: cfg.start_byte_second <= cfg_data[7:0];
        REG_CODE_SET_PWM: cfg.code_set_pwm      <= cfg_data[7:0];
        REG_CODE_STOP:    cfg.code_stop         <= cfg_data[7:0];
        REG_CODE_PING:    cfg.code_ping         <= cfg_data[7:0];
        REG_BYTE_GAP:     cfg.byte_gap_limit    <= cfg_data;
        REG_CMD_GAP:      cfg.command_gap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  cfcr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .item_en   (item_en),
    .is_tick   (is_tick),
    .data_byte (s_tdata),
    .cfg       (cfg),
    .frame     (frame)
  );

  // Watchdog: motor commands refresh it, ticks age it
  assign is_motor_cmd = (frame.evt == EV_SET_PWM) || (frame.evt == EV_STOP);

  always_comb begin
    command_seen_next      = command_seen;
    command_gap_count_next = command_gap_count;
    timeout_flag_next      = timeout_flag;
    if (is_tick) begin
      if (command_gap_count != GAP_MAX) command_gap_count_next = command_gap_count + 16'd1;
      timeout_flag_next = !command_seen ||
                          (command_gap_count_next > cfg.command_gap_limit);
    end else if (is_motor_cmd) begin
      command_seen_next      = 1'b1;
      command_gap_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_seen      <= 1'b0;
      command_gap_count <= '0;
      timeout_flag      <= 1'b1;
    end else if (item_en) begin
      command_seen      <= command_seen_next;
      command_gap_count <= command_gap_count_next;
      timeout_flag      <= timeout_flag_next;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (item_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_en) begin
      m_tuser <= frame.evt;
      m_tdata <= {6'b0, command_seen_next && !timeout_flag_next, timeout_flag_next,
                  frame.drive_b, frame.drive_a};
    end
  end

endmodule

// ----- rtl/cfcr_parser.sv -----
// Frame parser: start byte hunt, header, payload capture, CRC check, decode.
// Also keeps the byte gap counter. Depends on cfcr_pkg.
module cfcr_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_en,
  input  logic                 is_tick,
  input  logic [7:0]           data_byte,
  input  cfcr_pkg::cfcr_cfg_t  cfg,
  output cfcr_pkg::cfcr_frame_t frame
);
  import cfcr_pkg::*;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_START2 = 3'd1;
  localparam logic [2:0] PH_SEQ    = 3'd2;
  localparam logic [2:0] PH_CODE   = 3'd3;
  localparam logic [2:0] PH_LEN    = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;
  localparam logic [2:0] PH_CRC_LO = 3'd6;
  localparam logic [2:0] PH_CRC_HI = 3'd7;

  logic [2:0]  phase, phase_next, phase_eff;
  logic [4:0]  bytes_taken, bytes_taken_next, taken_inc;
  logic [7:0]  frame_code, frame_code_next;
  logic [4:0]  frame_length, frame_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] crc_cont, crc_fresh;
  logic [7:0]  crc_low_byte;
  logic [7:0]  payload_bytes [4];
  logic [15:0] byte_gap_count, byte_gap_count_next;
  logic        store_payload, store_crc_low;
  cfcr_frame_t frame_dec;

  assign crc_cont  = crc_feed(running_crc, data_byte);
  assign crc_fresh = crc_feed(CRC_INIT, data_byte);
  assign taken_inc = bytes_taken + 5'd1;

  // Decode a frame whose CRC matched; first matching code wins
  always_comb begin
    frame_dec = '0;
    if (frame_code == cfg.code_set_pwm) begin
      if (frame_length == PWM_PAYLOAD_LEN) begin
        frame_dec.evt     = EV_SET_PWM;
        frame_dec.drive_a = {payload_bytes[0], payload_bytes[1]};
        frame_dec.drive_b = {payload_bytes[2], payload_bytes[3]};
      end
    end else if (frame_code == cfg.code_stop) begin
      if (frame_length == 5'd0) frame_dec.evt = EV_STOP;
    end else if (frame_code == cfg.code_ping) begin
      if (frame_length == 5'd0) frame_dec.evt = EV_PING;
    end
  end

  // Next parser state for a received byte
  always_comb begin
    phase_next        = phase;
    bytes_taken_next  = bytes_taken;
    frame_code_next   = frame_code;
    frame_length_next = frame_length;
    running_crc_next  = running_crc;
    store_payload     = 1'b0;
    store_crc_low     = 1'b0;
    frame             = '0;

    // drop a partial frame after too long a gap
    phase_eff = (phase != PH_HUNT && byte_gap_count > cfg.byte_gap_limit) ? PH_HUNT : phase;

    case (phase_eff)
      PH_HUNT: begin
        if (data_byte == cfg.start_byte_first) begin
          running_crc_next = crc_fresh;
          phase_next       = PH_START2;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_START2: begin
        if (data_byte == cfg.start_byte_second) begin
          running_crc_next = crc_cont;
          phase_next       = PH_SEQ;
        end else if (data_byte == cfg.start_byte_first) begin
          running_crc_next = crc_fresh;
          phase_next       = PH_START2;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_SEQ: begin
        running_crc_next = crc_cont;
        phase_next       = PH_CODE;
      end
      PH_CODE: begin
        running_crc_next = crc_cont;
        frame_code_next  = data_byte;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        running_crc_next = crc_cont;
        bytes_taken_next = 5'd0;
        if (data_byte > PAYLOAD_LIMIT) begin
          phase_next = PH_HUNT;
        end else begin
          frame_length_next = data_byte[4:0];
          phase_next = (data_byte[4:0] == 5'd0) ? PH_CRC_LO : PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_cont;
        store_payload    = (bytes_taken < PAYLOAD_STORE);
        bytes_taken_next = taken_inc;
        if (taken_inc >= frame_length) phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        store_crc_low = 1'b1;
        phase_next    = PH_CRC_HI;
      end
      default: begin
        if ({data_byte, crc_low_byte} == running_crc) frame = frame_dec;
        phase_next       = PH_HUNT;
        bytes_taken_next = 5'd0;
      end
    endcase

    // ticks leave the parser alone
    if (is_tick) frame = '0;
  end

  // Age the gap counter on ticks, clear it on bytes
  always_comb begin
    if (is_tick) begin
      byte_gap_count_next = (byte_gap_count != GAP_MAX) ? byte_gap_count + 16'd1
                                                        : byte_gap_count;
    end else begin
      byte_gap_count_next = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      bytes_taken    <= '0;
      frame_code     <= '0;
      frame_length   <= '0;
      running_crc    <= CRC_INIT;
      byte_gap_count <= '0;
    end else if (item_en) begin
      byte_gap_count <= byte_gap_count_next;
      if (!is_tick) begin
        phase        <= phase_next;
        bytes_taken  <= bytes_taken_next;
        frame_code   <= frame_code_next;
        frame_length <= frame_length_next;
        running_crc  <= running_crc_next;
      end
    end
  end

  // Payload and CRC low byte capture
  always_ff @(posedge clk) begin
    if (item_en && !is_tick) begin
      if (store_payload) payload_bytes[bytes_taken[1:0]] <= data_byte;
      if (store_crc_low) crc_low_byte <= data_byte;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for crc_frame_command_receiver: byte and tick streams,
// directed and random, checked item by item against a behavioural predictor.
// Depends on cfcr_pkg and the receiver RTL only.
module testbench;
  import cfcr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int REPORT_MAX  = 10;
  localparam int PHASE_ITEMS = 180;

  localparam cfcr_cfg_t REG_DEFAULTS = '{
    start_byte_first: 8'hA5, start_byte_second: 8'h5A,
    code_set_pwm: 8'h01, code_stop: 8'h02, code_ping: 8'h03,
    byte_gap_limit: 16'd20, command_gap_limit: 16'd100};

  typedef enum logic [2:0] {
    PH_HUNT, PH_START2, PH_SEQ, PH_CODE, PH_LEN, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
  } parse_phase_e;

  typedef struct {
    logic       is_tick;
    logic [7:0] data;
  } rx_item_t;

  typedef struct {
    logic [1:0]         evt;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic               timed_out;
    logic               active;
  } cmd_result_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [15:0] drive_a, [31:16] drive_b, [32] timeout, [33] active
  logic [1:0]  m_tuser;           // [1:0] event_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;

  crc_frame_command_receiver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench-side copy of the registers and of the receiver state
  cfcr_cfg_t    regs_now = REG_DEFAULTS;
  parse_phase_e ph = PH_HUNT;
  logic [4:0]   pay_cnt = '0;
  logic [7:0]   cur_code = '0;
  logic [4:0]   cur_len = '0;
  logic [15:0]  crc_acc = CRC_INIT;
  logic [7:0]   crc_lo = '0;
  logic [7:0]   pay [4] = '{default: 8'h00};
  logic [15:0]  byte_idle = '0;
  logic [15:0]  cmd_idle = '0;
  logic         cmd_seen = 1'b0;
  logic         timeout_now = 1'b1;

  rx_item_t     rx_backlog[$];
  cmd_result_t  awaited_replies[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  bit hold_start = 1'b0;
  int queued_items = 0;
  int bytes_sent = 0;
  int ticks_sent = 0;
  int replies_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int ev_count [4] = '{default: 0};

  // CRC-16/Modbus, reflected, one byte at a time
  function automatic logic [15:0] fold_crc(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Advance the predicted receiver by one item and queue the reply it gives
  task automatic predict_receiver(input logic is_tick, input logic [7:0] b);
    cmd_result_t r;
    r.evt = EV_NONE;
    r.drive_a = '0;
    r.drive_b = '0;
    if (is_tick) begin
      if (byte_idle != GAP_MAX) byte_idle = byte_idle + 16'd1;
      if (cmd_idle != GAP_MAX) cmd_idle = cmd_idle + 16'd1;
      timeout_now = !cmd_seen || (cmd_idle > regs_now.command_gap_limit);
    end else begin
      // a late byte drops the partial frame and is parsed afresh
      if (ph != PH_HUNT && byte_idle > regs_now.byte_gap_limit) ph = PH_HUNT;
      byte_idle = '0;
      case (ph)
        PH_HUNT: begin
          if (b == regs_now.start_byte_first) begin
            crc_acc = fold_crc(CRC_INIT, b);
            ph = PH_START2;
          end
        end
        PH_START2: begin
          if (b == regs_now.start_byte_second) begin
            crc_acc = fold_crc(crc_acc, b);
            ph = PH_SEQ;
          end else if (b == regs_now.start_byte_first) begin
            crc_acc = fold_crc(CRC_INIT, b);
          end else begin
            ph = PH_HUNT;
          end
        end
        PH_SEQ: begin
          crc_acc = fold_crc(crc_acc, b);
          ph = PH_CODE;
        end
        PH_CODE: begin
          crc_acc = fold_crc(crc_acc, b);
          cur_code = b;
          ph = PH_LEN;
        end
        PH_LEN: begin
          crc_acc = fold_crc(crc_acc, b);
          pay_cnt = '0;
          if (b > PAYLOAD_LIMIT) begin
            ph = PH_HUNT;
          end else begin
            cur_len = b[4:0];
            ph = (cur_len == 5'd0) ? PH_CRC_LO : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_acc = fold_crc(crc_acc, b);
          if (pay_cnt < PAYLOAD_STORE) pay[pay_cnt[1:0]] = b;
          pay_cnt = pay_cnt + 5'd1;
          if (pay_cnt >= cur_len) ph = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo = b;
          ph = PH_CRC_HI;
        end
        default: begin
          // set-PWM wins over stop, stop over ping, when codes coincide
          if ({b, crc_lo} == crc_acc) begin
            if (cur_code == regs_now.code_set_pwm) begin
              if (cur_len == PWM_PAYLOAD_LEN) begin
                r.evt = EV_SET_PWM;
                r.drive_a = {pay[0], pay[1]};
                r.drive_b = {pay[2], pay[3]};
                cmd_seen = 1'b1;
                cmd_idle = '0;
              end
            end else if (cur_code == regs_now.code_stop) begin
              if (cur_len == 5'd0) begin
                r.evt = EV_STOP;
                cmd_seen = 1'b1;
                cmd_idle = '0;
              end
            end else if (cur_code == regs_now.code_ping && cur_len == 5'd0) begin
              r.evt = EV_PING;
            end
          end
          ph = PH_HUNT;
          pay_cnt = '0;
        end
      endcase
    end
    r.timed_out = timeout_now;
    r.active = cmd_seen && !timeout_now;
    awaited_replies.push_back(r);
  endtask

  // Input side: present backlog items, predict each one as it is taken
  always @(posedge clk) begin : feed
    rx_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_receiver(s_tuser, s_tdata);
        if (s_tuser) ticks_sent++;
        else bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = rx_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.data;
          s_tuser <= nxt.is_tick;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_start) hold_left <= HOLD_CYCLES;
  end

  task automatic note_miss(input string what, input logic [15:0] want, input logic [15:0] got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("reply %0d, %s: expected %0h, got %0h", replies_seen, what, want, got);
  endtask

  // Output side: take replies and compare against the oldest prediction
  always @(posedge clk) begin : watch
    cmd_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("reply with no item outstanding: tuser %0h tdata %0h", m_tuser, m_tdata);
        end else begin
          want = awaited_replies.pop_front();
          ev_count[want.evt]++;
          if (m_tuser !== want.evt)
            note_miss("event", 16'(want.evt), 16'(m_tuser));
          if (m_tdata[15:0] !== want.drive_a)
            note_miss("drive_a", want.drive_a, m_tdata[15:0]);
          if (m_tdata[31:16] !== want.drive_b)
            note_miss("drive_b", want.drive_b, m_tdata[31:16]);
          if (m_tdata[32] !== want.timed_out)
            note_miss("timeout", 16'(want.timed_out), 16'(m_tdata[32]));
          if (m_tdata[33] !== want.active)
            note_miss("active", 16'(want.active), 16'(m_tdata[33]));
          if (m_tdata[39:34] !== 6'd0)
            note_miss("padding", 16'd0, 16'(m_tdata[39:34]));
        end
        replies_seen++;
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit hit, %0d items queued, %0d replies outstanding",
               rx_backlog.size(), awaited_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(input logic is_tick, input logic [7:0] data);
    rx_item_t it;
    it.is_tick = is_tick;
    it.data = data;
    rx_backlog.push_back(it);
    queued_items++;
  endtask

  task automatic push_tick();
    push_item(1'b1, 8'($urandom_range(255)));
  endtask

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // Tick count close to a limit within reach, so both sides of it are hit; else 1 to 6 ticks
  function automatic int near_limit(input int lim, input int reach);
    if (lim <= reach) return (lim > 0 ? lim - 1 : 0) + $urandom_range(3);
    return $urandom_range(1, 6);
  endfunction

  // Queue a whole frame; optionally spoil the CRC or stall mid-frame with ticks
  task automatic push_frame(input logic [7:0] code, input logic [7:0] len_byte,
                            input byte_q_t body, input bit spoil, input int gap_ticks);
    byte_q_t     fr;
    logic [15:0] crc;
    int          cut;
    fr.push_back(regs_now.start_byte_first);
    fr.push_back(regs_now.start_byte_second);
    fr.push_back(8'($urandom_range(255)));
    fr.push_back(code);
    fr.push_back(len_byte);
    foreach (body[i]) fr.push_back(body[i]);
    crc = CRC_INIT;
    foreach (fr[i]) crc = fold_crc(crc, fr[i]);
    if (spoil) crc = crc ^ (16'd1 << $urandom_range(15));
    fr.push_back(crc[7:0]);
    fr.push_back(crc[15:8]);
    cut = (gap_ticks > 0) ? $urandom_range(1, fr.size() - 1) : -1;
    foreach (fr[i]) begin
      if (i == cut) repeat (gap_ticks) push_tick();
      push_item(1'b0, fr[i]);
    end
  endtask

  // Mostly known commands with their proper length, sometimes odd ones
  task automatic push_command_frame(input bit spoil, input int gap_ticks);
    logic [7:0] code;
    int         len;
    case ($urandom_range(3))
      0: code = regs_now.code_set_pwm;
      1: code = regs_now.code_stop;
      2: code = regs_now.code_ping;
      default: code = 8'($urandom_range(255));
    endcase
    len = (code == regs_now.code_set_pwm) ? int'(PWM_PAYLOAD_LEN) : 0;
    if ($urandom_range(9) == 0) len = $urandom_range(int'(PAYLOAD_LIMIT));
    push_frame(code, 8'(len), random_bytes(len), spoil, gap_ticks);
  endtask

  task automatic push_random_traffic(input int n);
    int stop_at;
    int pick;
    stop_at = queued_items + n;
    while (queued_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_command_frame(1'b0, ($urandom_range(7) == 0) ?
                           near_limit(regs_now.byte_gap_limit, 40) : 0);
      end else if (pick < 63) begin
        push_command_frame(1'b1, 0);
      end else if (pick < 68) begin
        // length over the limit
        push_frame(8'($urandom_range(255)), 8'($urandom_range(int'(PAYLOAD_LIMIT) + 1, 255)),
                   random_bytes($urandom_range(4)), 1'b0, 0);
      end else if (pick < 74) begin
        push_item(1'b0, regs_now.start_byte_first);
        push_command_frame(1'b0, 0);
      end else if (pick < 78) begin
        push_item(1'b0, regs_now.start_byte_first);
        push_item(1'b0, 8'($urandom_range(255)));
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3)) push_tick();
      end else if (pick < 91) begin
        repeat (near_limit(regs_now.command_gap_limit, 150)) push_tick();
      end else begin
        repeat ($urandom_range(1, 4)) push_item(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_START_FIRST:  regs_now.start_byte_first = val[7:0];
      REG_START_SECOND: regs_now.start_byte_second = val[7:0];
      REG_CODE_SET_PWM: regs_now.code_set_pwm = val[7:0];
      REG_CODE_STOP:    regs_now.code_stop = val[7:0];
      REG_CODE_PING:    regs_now.code_ping = val[7:0];
      REG_BYTE_GAP:     regs_now.byte_gap_limit = val;
      REG_CMD_GAP:      regs_now.command_gap_limit = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input cfcr_cfg_t c);
    write_reg(REG_START_FIRST, {8'h00, c.start_byte_first});
    write_reg(REG_START_SECOND, {8'h00, c.start_byte_second});
    write_reg(REG_CODE_SET_PWM, {8'h00, c.code_set_pwm});
    write_reg(REG_CODE_STOP, {8'h00, c.code_stop});
    write_reg(REG_CODE_PING, {8'h00, c.code_ping});
    write_reg(REG_BYTE_GAP, c.byte_gap_limit);
    write_reg(REG_CMD_GAP, c.command_gap_limit);
    @(negedge clk);
  endtask

  // Wait until every item is sent and every reply is back
  task automatic wait_drained();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || s_tvalid || awaited_replies.size() != 0);
  endtask

  initial begin : stimulus
    cfcr_cfg_t c;
    byte_q_t   none;
    byte_q_t   pwm_body;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values, no idling: directed opening then random
    pwm_body = '{8'h80, 8'h00, 8'h7F, 8'hFF};
    push_tick();
    push_item(1'b0, regs_now.start_byte_first);
    push_frame(regs_now.code_set_pwm, 8'(PWM_PAYLOAD_LEN), pwm_body, 1'b0, 0);
    push_frame(regs_now.code_stop, 8'd0, none, 1'b0, 0);
    push_frame(regs_now.code_ping, 8'd0, none, 1'b0, 0);
    push_random_traffic(PHASE_ITEMS);
    wait_drained();

    // Extreme byte values, zero gap limits; sender mostly idle
    write_all('{start_byte_first: 8'h00, start_byte_second: 8'hFF,
                code_set_pwm: 8'hFF, code_stop: 8'h00, code_ping: 8'h80,
                byte_gap_limit: 16'd0, command_gap_limit: 16'd0});
    send_idle_pct = 83;
    recv_stall_pct = 0;
    push_random_traffic(PHASE_ITEMS);
    wait_drained();

    // Equal start bytes, all codes alike, gap limits one below the counter maximum; receiver mostly stalled
    write_all('{start_byte_first: 8'h5A, start_byte_second: 8'h5A,
                code_set_pwm: 8'h07, code_stop: 8'h07, code_ping: 8'h07,
                byte_gap_limit: 16'd65534, command_gap_limit: 16'd65534});
    send_idle_pct = 0;
    recv_stall_pct = 83;
    push_random_traffic(PHASE_ITEMS);
    wait_drained();

    // Random settings with short limits; both sides idle now and then
    c.start_byte_first = 8'($urandom_range(255));
    c.start_byte_second = 8'($urandom_range(255));
    c.code_set_pwm = 8'($urandom_range(255));
    c.code_stop = 8'($urandom_range(255));
    c.code_ping = 8'($urandom_range(255));
    c.byte_gap_limit = 16'($urandom_range(30));
    c.command_gap_limit = 16'($urandom_range(150));
    write_all(c);
    send_idle_pct = 32;
    recv_stall_pct = 32;
    push_random_traffic(PHASE_ITEMS);
    wait_drained();

    // Defaults again; long receiver hold-off while the sender keeps offering
    write_all(REG_DEFAULTS);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_random_traffic(PHASE_ITEMS);
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    wait_drained();

    repeat (4) @(posedge clk);
    $display("Run covered %0d bytes and %0d ticks in five phases of stalls and gaps.",
             bytes_sent, ticks_sent);
    $display("Decoded %0d set-PWM, %0d stop, %0d ping; %0d field mismatches.",
             ev_count[EV_SET_PWM], ev_count[EV_STOP], ev_count[EV_PING], mismatches);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
